@@ rtl/sha1_pkg.sv @@
// Shared types and constants for the SHA-1 digest core.
`default_nettype none

package sha1_pkg;

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  valid_bytes;
        logic        last;
    } sha1_in_t;

    typedef struct packed {
        logic [31:0] digest_0;
        logic [31:0] digest_1;
        logic [31:0] digest_2;
        logic [31:0] digest_3;
        logic [31:0] digest_4;
    } sha1_out_t;

    localparam int unsigned WIN_DEPTH = 16;
    localparam int unsigned WIN_AW    = 4;
    localparam int unsigned ROUND_CYC = 160;

    localparam logic [31:0] IV_0 = 32'h6745_2301;
    localparam logic [31:0] IV_1 = 32'hEFCD_AB89;
    localparam logic [31:0] IV_2 = 32'h98BA_DCFE;
    localparam logic [31:0] IV_3 = 32'h1032_5476;
    localparam logic [31:0] IV_4 = 32'hC3D2_E1F0;

    localparam logic [31:0] K_0 = 32'h5A82_7999;
    localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K_3 = 32'hCA62_C1D6;

    localparam logic [31:0] PAD_MARK = 32'h8000_0000;

endpackage

`default_nettype wire

@@ rtl/sha1_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module sha1_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

`default_nettype wire

@@ rtl/sha1_digest_core.sv @@
// SHA-1 digest core: streaming input, built-in padding, schedule window in RAM.
//
//  channel | direction | payload    | handshake
//  s_      | in        | sha1_in_t  | s_valid / s_ready
//  m_      | out       | sha1_out_t | m_valid / m_ready
//
// Words are taken while idle; every 16th word starts a block of rounds plus a finish
// step, and no further word is taken until that block is done.
// Rounds complete on even cycles only, because each needs four window words through
// the two read ports of the schedule RAM. Padding words go in at one per cycle.
// Reset is synchronous (aresetn low); the window RAM needs no clearing pass.
// A finished digest waits in the output register; the next message streams in
// meanwhile, and only its own finish cycle waits for the previous digest to leave.
`default_nettype none

module sha1_digest_core
    import sha1_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire sha1_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output sha1_out_t      m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FIN
    } state_t;

    state_t          state_reg;
    logic [WIN_AW-1:0] pos_reg;
    logic [63:0]     cnt_reg;
    logic [31:0]     chain_reg [5];
    logic [31:0]     a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [7:0]      cyc_reg;
    logic [31:0]     ws_reg;
    logic [31:0]     wx_reg;
    logic            pad_reg;
    logic            mark_reg;
    logic            hi_done_reg;
    logic            final_reg;
    logic            m_valid_reg;
    sha1_out_t       out_reg;

    // RAM ports
    logic              ram_we;
    logic [WIN_AW-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic [WIN_AW-1:0] ram_raddr0;
    logic [WIN_AW-1:0] ram_raddr1;
    logic [31:0]       ram_rdata0;
    logic [31:0]       ram_rdata1;

    sha1_ram #(
        .WIDTH (32),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .clk    (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .raddr1 (ram_raddr1),
        .rdata0 (ram_rdata0),
        .rdata1 (ram_rdata1)
    );

    // Input word shaping
    logic        accept;
    logic [2:0]  nbytes;
    logic [31:0] keep_mask;
    logic [31:0] pad_bit;
    logic [31:0] in_word;
    logic [63:0] bit_len;
    logic [31:0] pad_word;

    assign accept  = s_valid && s_ready;
    assign nbytes  = (s_data.last && s_data.valid_bytes <= 3'd4) ? s_data.valid_bytes : 3'd4;
    assign bit_len = {cnt_reg[60:0], 3'b000};

    always_comb begin
        case (nbytes)
            3'd0: begin
                keep_mask = 32'h0000_0000;
                pad_bit   = 32'h8000_0000;
            end
            3'd1: begin
                keep_mask = 32'hFF00_0000;
                pad_bit   = 32'h0080_0000;
            end
            3'd2: begin
                keep_mask = 32'hFFFF_0000;
                pad_bit   = 32'h0000_8000;
            end
            3'd3: begin
                keep_mask = 32'hFFFF_FF00;
                pad_bit   = 32'h0000_0080;
            end
            default: begin
                keep_mask = 32'hFFFF_FFFF;
                pad_bit   = 32'h0000_0000;
            end
        endcase
        in_word = (s_data.msg_word & keep_mask) | pad_bit;
    end

    always_comb begin
        if (mark_reg) begin
            pad_word = PAD_MARK;
        end else if (hi_done_reg) begin
            pad_word = bit_len[31:0];
        end else if (pos_reg == 4'd14) begin
            pad_word = bit_len[63:32];
        end else begin
            pad_word = 32'h0;
        end
    end

    // Round datapath: rounds complete on even cycles
    logic [6:0]        rc;
    logic [WIN_AW-1:0] sc;
    logic [WIN_AW-1:0] si;
    logic              round_go;
    logic [31:0]       w_mix;
    logic [31:0]       w_new;
    logic [31:0]       wt;
    logic [31:0]       f_val;
    logic [31:0]       k_val;
    logic [31:0]       tmp;

    assign rc       = cyc_reg[7:1] - 7'd1;
    assign sc       = rc[3:0];
    assign si       = cyc_reg[4:1];
    assign round_go = (state_reg == ST_COMP) && !cyc_reg[0] && (cyc_reg != 8'd0);
    assign w_mix    = wx_reg ^ ram_rdata0 ^ ram_rdata1;
    assign w_new    = {w_mix[30:0], w_mix[31]};
    assign wt       = (rc < 7'd16) ? ws_reg : w_new;

    always_comb begin
        if (rc < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end else if (rc < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end else if (rc < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
        tmp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + wt + k_val;
    end

    // Window RAM access
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = in_word;
        unique case (state_reg)
            ST_IDLE: begin
                ram_we = accept;
            end
            ST_PAD: begin
                ram_we    = 1'b1;
                ram_wdata = pad_word;
            end
            ST_COMP: begin
                ram_we    = round_go && (rc >= 7'd16);
                ram_waddr = sc;
                ram_wdata = w_new;
            end
            ST_FIN: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        // even cycle: w[s], w[s+2]; odd cycle: w[s+13], w[s+8]
        ram_raddr0 = cyc_reg[0] ? si + 4'd13 : si;
        ram_raddr1 = cyc_reg[0] ? si + 4'd8  : si + 4'd2;
    end

    logic [31:0] sum [5];

    assign sum[0] = chain_reg[0] + a_reg;
    assign sum[1] = chain_reg[1] + b_reg;
    assign sum[2] = chain_reg[2] + c_reg;
    assign sum[3] = chain_reg[3] + d_reg;
    assign sum[4] = chain_reg[4] + e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            cnt_reg      <= '0;
            chain_reg[0] <= IV_0;
            chain_reg[1] <= IV_1;
            chain_reg[2] <= IV_2;
            chain_reg[3] <= IV_3;
            chain_reg[4] <= IV_4;
            cyc_reg      <= '0;
            pad_reg      <= 1'b0;
            mark_reg     <= 1'b0;
            hi_done_reg  <= 1'b0;
            final_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // drop the word once taken, unless a new digest replaces it this cycle
            if (m_valid_reg && m_ready && !(state_reg == ST_FIN && final_reg)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cnt_reg <= cnt_reg + {61'b0, nbytes};
                        pos_reg <= pos_reg + 4'd1;
                        if (s_data.last) begin
                            pad_reg     <= 1'b1;
                            mark_reg    <= (nbytes == 3'd4);
                            hi_done_reg <= 1'b0;
                        end
                        if (pos_reg == 4'd15) begin
                            state_reg <= ST_COMP;
                        end else if (s_data.last) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    mark_reg <= 1'b0;
                    pos_reg  <= pos_reg + 4'd1;
                    if (hi_done_reg) begin
                        final_reg <= 1'b1;
                    end else if (!mark_reg && pos_reg == 4'd14) begin
                        hi_done_reg <= 1'b1;
                    end
                    if (pos_reg == 4'd15) begin
                        state_reg <= ST_COMP;
                    end
                end
                ST_COMP: begin
                    cyc_reg <= cyc_reg + 8'd1;
                    if (cyc_reg[0]) begin
                        ws_reg <= ram_rdata0;
                        wx_reg <= ram_rdata0 ^ ram_rdata1;
                    end
                    if (round_go) begin
                        a_reg <= tmp;
                        b_reg <= a_reg;
                        c_reg <= {b_reg[1:0], b_reg[31:2]};
                        d_reg <= c_reg;
                        e_reg <= d_reg;
                    end
                    if (cyc_reg == 8'(ROUND_CYC)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    cyc_reg <= '0;
                    if (!final_reg) begin
                        for (int i = 0; i < 5; i++) begin
                            chain_reg[i] <= sum[i];
                        end
                        state_reg <= pad_reg ? ST_PAD : ST_IDLE;
                    end else if (!m_valid_reg || m_ready) begin
                        // hand off the digest and start a fresh message
                        out_reg.digest_0 <= sum[0];
                        out_reg.digest_1 <= sum[1];
                        out_reg.digest_2 <= sum[2];
                        out_reg.digest_3 <= sum[3];
                        out_reg.digest_4 <= sum[4];
                        m_valid_reg      <= 1'b1;
                        chain_reg[0]     <= IV_0;
                        chain_reg[1]     <= IV_1;
                        chain_reg[2]     <= IV_2;
                        chain_reg[3]     <= IV_3;
                        chain_reg[4]     <= IV_4;
                        cnt_reg          <= '0;
                        pad_reg          <= 1'b0;
                        mark_reg         <= 1'b0;
                        hi_done_reg      <= 1'b0;
                        final_reg        <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // load working variables as a block starts
            if (state_reg != ST_COMP && state_reg != ST_FIN && ram_we && pos_reg == 4'd15) begin
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
                e_reg <= chain_reg[4];
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    a_start_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP && cyc_reg == 8'd0) |-> pos_reg == 4'd0)
        else $error("block started with window not full");

    a_sched_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP && ram_we) |-> (rc >= 7'd16 && !cyc_reg[0]))
        else $error("schedule written outside an expansion round");

    a_fin_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && $past(state_reg) == ST_COMP)
            |-> $past(cyc_reg) == 8'(ROUND_CYC))
        else $error("finish reached before all rounds ran");

    a_digest_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FIN && $past(final_reg)))
        else $error("digest presented outside the final finish cycle");

    a_length_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAD && hi_done_reg && !mark_reg) |-> pos_reg == 4'd15)
        else $error("low length word misplaced");
`endif

endmodule

`default_nettype wire

@@ sim/sha1_digest_core_tb.sv @@
// Self-checking testbench for sha1_digest_core: random streamed messages vs. a built-in SHA-1 model.
module sha1_digest_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 400;
    localparam int SHOW_LIMIT  = 40;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sha1_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sha1_out_t m_data;

    sha1_digest_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Stimulus queues: word and whether to wait for all digests before sending it
    sha1_in_t  word_q[$];
    bit        hold_q[$];
    sha1_out_t digest_q[$];

    int digests_owed  = 0;
    int digests_taken = 0;
    int errors        = 0;
    int send_gap      = 0;
    int recv_gap      = 0;
    int quiet         = 0;
    bit send_calm     = 1'b0;
    bit recv_calm     = 1'b0;

    // Hash state of the predictor
    logic [31:0] chain_h[5];
    logic [31:0] sched_w[16];
    logic [3:0]  slot_idx;
    logic [63:0] byte_total;

    function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic clear_chain();
        chain_h[0] = IV_0;
        chain_h[1] = IV_1;
        chain_h[2] = IV_2;
        chain_h[3] = IV_3;
        chain_h[4] = IV_4;
        slot_idx   = '0;
        byte_total = '0;
    endtask

    // Place a word in the window; compress once all 16 slots are filled
    task automatic feed_window(input logic [31:0] wd);
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        int          t, s;
        sched_w[slot_idx] = wd;
        slot_idx = slot_idx + 4'd1;
        if (slot_idx == 4'd0) begin
            w = sched_w;
            a = chain_h[0];
            b = chain_h[1];
            c = chain_h[2];
            d = chain_h[3];
            e = chain_h[4];
            for (t = 0; t < 80; t++) begin
                s = t % 16;
                if (t >= 16)
                    w[s] = rol(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
                case (t / 20)
                    0: begin
                        f = (b & c) | (~b & d);
                        k = K_0;
                    end
                    1: begin
                        f = b ^ c ^ d;
                        k = K_1;
                    end
                    2: begin
                        f = (b & c) | (b & d) | (c & d);
                        k = K_2;
                    end
                    default: begin
                        f = b ^ c ^ d;
                        k = K_3;
                    end
                endcase
                tmp = rol(a, 5) + f + e + w[s] + k;
                e = d;
                d = c;
                c = rol(b, 30);
                b = a;
                a = tmp;
            end
            chain_h[0] = chain_h[0] + a;
            chain_h[1] = chain_h[1] + b;
            chain_h[2] = chain_h[2] + c;
            chain_h[3] = chain_h[3] + d;
            chain_h[4] = chain_h[4] + e;
        end
    endtask

    // Absorb one accepted word; on the last word pad, finish and return the digest
    task automatic hash_word(input sha1_in_t wd, output bit done, output sha1_out_t dg);
        int          nb;
        logic [31:0] keep;
        logic [63:0] bits;
        nb = (wd.valid_bytes > 3'd4 || !wd.last) ? 4 : int'(wd.valid_bytes);
        byte_total = byte_total + 64'(nb);
        done = wd.last;
        dg = '0;
        if (!wd.last) begin
            feed_window(wd.msg_word);
        end else begin
            if (nb == 4) begin
                feed_window(wd.msg_word);
                feed_window(PAD_MARK);
            end else begin
                keep = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
                feed_window((wd.msg_word & keep) | (PAD_MARK >> (8 * nb)));
            end
            while (slot_idx != 4'd14)
                feed_window(32'h0);
            bits = byte_total << 3;
            feed_window(bits[63:32]);
            feed_window(bits[31:0]);
            dg = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
            clear_chain();
        end
    endtask

    task automatic queue_word(input logic [31:0] wd, input logic [2:0] vb, input bit lst,
                              input bit hold);
        sha1_in_t it;
        it.msg_word    = wd;
        it.valid_bytes = vb;
        it.last        = lst;
        word_q.push_back(it);
        hold_q.push_back(hold);
    endtask

    // Random message of len bytes; an exact multiple of 4 may end on a full or an empty word
    task automatic queue_message(input int len, input bit hold);
        int          nfull, rem, i;
        logic [2:0]  vb;
        bit          h;
        nfull = len / 4;
        rem   = len % 4;
        h     = hold;
        if (rem == 0 && nfull > 0 && $urandom_range(0, 1) == 1) begin
            nfull--;
            rem = 4;
        end
        for (i = 0; i < nfull; i++) begin
            vb = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            queue_word($urandom, vb, 1'b0, h);
            h = 1'b0;
        end
        if (rem == 4 && $urandom_range(0, 7) == 0)
            vb = 3'($urandom_range(5, 7));
        else
            vb = 3'(rem);
        queue_word($urandom, vb, 1'b1, h);
    endtask

    // Driver: present queued words, predict on every accepted word
    always @(posedge aclk) begin : drive_p
        logic      nxt_valid;
        int        owed;
        bit        fin;
        sha1_out_t dg;
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_chain();
        end else begin
            nxt_valid = s_valid;
            owed = digests_owed;
            if (s_valid && s_ready) begin
                hash_word(s_data, fin, dg);
                if (fin) begin
                    digest_q.push_back(dg);
                    owed++;
                end
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && word_q.size() != 0) begin
                if (hold_q[0] && owed != digests_taken) begin
                    // hold until every outstanding digest has left
                end else if (send_gap != 0) begin
                    send_gap--;
                end else begin
                    nxt_valid = 1'b1;
                    s_data <= word_q.pop_front();
                    void'(hold_q.pop_front());
                    if ($urandom_range(0, 63) == 0)
                        send_calm = !send_calm;
                    send_gap = send_calm ? 0 : $urandom_range(0, 10);
                end
            end
            s_valid <= nxt_valid;
            digests_owed <= owed;
        end
    end

    // Monitor: stall at random, compare every digest with the oldest prediction
    always @(posedge aclk) begin : collect_p
        sha1_out_t want;
        int        i;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display("%0t ns: unexpected digest, expected none got %h", $time,
                                 m_data);
                end else begin
                    want = digest_q.pop_front();
                    for (i = 0; i < 5; i++) begin
                        if (want[159 - 32 * i -: 32] !== m_data[159 - 32 * i -: 32]) begin
                            errors++;
                            if (errors <= SHOW_LIMIT)
                                $display("%0t ns: digest_%0d expected %08h got %08h", $time,
                                         i, want[159 - 32 * i -: 32],
                                         m_data[159 - 32 * i -: 32]);
                        end
                    end
                end
                digests_taken <= digests_taken + 1;
                if ($urandom_range(0, 63) == 0)
                    recv_calm = !recv_calm;
                recv_gap = recv_calm ? 0 : $urandom_range(0, 10);
            end else if (m_valid && recv_gap != 0) begin
                recv_gap--;
            end
            m_ready <= (recv_gap == 0);
        end
    end

    // Watchdog: too long without a word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet == QUIET_LIMIT) begin
                $display("** sha1_digest_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int r, len;

        // directed: empty message with garbage bits, "abc" after a full drain
        queue_word(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0);
        queue_word(32'h6162_63FF, 3'd3, 1'b1, 1'b1);
        queue_word(32'hFFFF_FFFF, 3'd1, 1'b1, 1'b0);
        queue_word(32'h0000_0000, 3'd2, 1'b1, 1'b0);
        queue_word(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0);
        // oversized byte counts on the last word
        queue_word(32'h0000_0000, 3'd5, 1'b1, 1'b0);
        queue_word(32'hFFFF_FFFF, 3'd6, 1'b1, 1'b0);
        queue_word($urandom, 3'd7, 1'b1, 1'b0);
        // short or oversized counts on words that are not last count as full words
        queue_word(32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0);
        queue_word(32'h0000_0000, 3'd3, 1'b0, 1'b0);
        queue_word($urandom, 3'd7, 1'b0, 1'b0);
        queue_word($urandom, 3'd2, 1'b1, 1'b0);
        queue_word(32'hFFFF_FFFF, 3'd4, 1'b0, 1'b1);
        queue_word(32'h0000_0000, 3'd1, 1'b1, 1'b0);

        // random messages, biased toward the one/two block padding boundary
        while (word_q.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                len = $urandom_range(0, 40);
            else if (r < 75)
                len = $urandom_range(52, 68);
            else if (r < 92)
                len = $urandom_range(0, 130);
            else
                len = $urandom_range(130, 260);
            queue_message(len, $urandom_range(0, 31) == 0);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (word_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (digests_owed != digests_taken)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (digest_q.size() != 0) begin
            errors++;
            $display("%0t ns: %0d digests expected but never delivered", $time,
                     digest_q.size());
        end
        if (errors == 0)
            $display("** sha1_digest_core: PASSED **");
        else
            $display("** sha1_digest_core: FAILED **");
        $finish;
    end

endmodule

@@ sha1_digest_core.f @@
rtl/sha1_pkg.sv
rtl/sha1_ram.sv
rtl/sha1_digest_core.sv
sim/sha1_digest_core_tb.sv
